@@ hw/rtl/ddtw_pkg.sv @@
`default_nettype none

package ddtw_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_BASE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_PALETTE = 1'b1;

    // divide by ten as multiply by reciprocal, exact for 16-bit operands
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // micro-operations driven into the datapath
    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DIVIDE = 2'd2,
        OP_EMIT   = 2'd3
    } uop_t;

    // jump conditions
    typedef enum logic [1:0] {
        JMP_NEVER      = 2'd0,
        JMP_ALWAYS     = 2'd1,
        JMP_COUNT_ZERO = 2'd2,
        JMP_COL_NZ     = 2'd3
    } jcond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_LOAD   = 3'd0;
    localparam step_t STEP_DIVIDE = 3'd1;
    localparam step_t STEP_UPPER  = 3'd2;
    localparam step_t STEP_LOWER  = 3'd3;
    localparam step_t STEP_RETURN = 3'd4;

    // one control word of the microprogram
    typedef struct packed {
        uop_t   op;
        logic   half;
        jcond_t cond;
        step_t  target;
    } uword_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic go;          // handshake of the current step completes
        logic count_zero;  // incoming transaction draws no digits
        logic col_nz;      // columns remain after the current one
    } dp_status_t;

    // microprogram store
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        case (step)
            STEP_LOAD:   w = '{op: OP_LOAD,   half: 1'b0, cond: JMP_COUNT_ZERO, target: STEP_LOAD};
            STEP_DIVIDE: w = '{op: OP_DIVIDE, half: 1'b0, cond: JMP_NEVER,      target: STEP_LOAD};
            STEP_UPPER:  w = '{op: OP_EMIT,   half: 1'b0, cond: JMP_NEVER,      target: STEP_LOAD};
            STEP_LOWER:  w = '{op: OP_EMIT,   half: 1'b1, cond: JMP_COL_NZ,     target: STEP_DIVIDE};
            STEP_RETURN: w = '{op: OP_NOP,    half: 1'b0, cond: JMP_ALWAYS,     target: STEP_LOAD};
            default:     w = '{op: OP_NOP,    half: 1'b0, cond: JMP_ALWAYS,     target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ddtw_if.sv @@
`default_nettype none

// number to draw
interface ddtw_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  left_column;
    logic [7:0]  top_row;
    logic [15:0] number;
    logic [3:0]  digit_count;

    modport source (output valid, output left_column, output top_row, output number,
                    output digit_count, input ready);
    modport sink   (input valid, input left_column, input top_row, input number,
                    input digit_count, output ready);
endinterface

// one tile write
interface ddtw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tile_column;
    logic [7:0] tile_row;
    logic [7:0] tile_number;
    logic       on_screen;
    logic       last;

    modport source (output valid, output tile_column, output tile_row, output tile_number,
                    output on_screen, output last, input ready);
    modport sink   (input valid, input tile_column, input tile_row, input tile_number,
                    input on_screen, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ddtw_useq.sv @@
`default_nettype none

module ddtw_useq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ddtw_pkg::dp_status_t status,
    output ddtw_pkg::uword_t         ctrl
);

    ddtw_pkg::step_t step_reg;
    ddtw_pkg::step_t step_next;
    logic            taken;
    logic            stall;

    // control word fetch
    assign ctrl = ddtw_pkg::ucode_rom(step_reg);

    // jump condition and stall on handshake steps
    always_comb
    begin
        case (ctrl.cond)
            ddtw_pkg::JMP_NEVER:      taken = 1'b0;
            ddtw_pkg::JMP_ALWAYS:     taken = 1'b1;
            ddtw_pkg::JMP_COUNT_ZERO: taken = status.count_zero;
            ddtw_pkg::JMP_COL_NZ:     taken = status.col_nz;
            default:                  taken = 1'b0;
        endcase
        stall = ((ctrl.op == ddtw_pkg::OP_LOAD) || (ctrl.op == ddtw_pkg::OP_EMIT))
                && !status.go;
        step_next = step_reg;
        if (!stall)
        begin
            step_next = taken ? ctrl.target : step_reg + 3'd1;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ddtw_pkg::STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // program counter stays inside the program
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= ddtw_pkg::STEP_RETURN)
        else $error("step counter left the program");

    // a transaction with digits goes straight to the first division
    a_load_to_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == ddtw_pkg::OP_LOAD && status.go && !status.count_zero)
        |=> step_reg == ddtw_pkg::STEP_DIVIDE)
        else $error("load did not start conversion");

    // a blocked tile write holds its step
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == ddtw_pkg::OP_EMIT && !status.go) |=> $stable(step_reg))
        else $error("sequencer advanced past a blocked write");

endmodule

`default_nettype wire

@@ hw/rtl/ddtw_datapath.sv @@
`default_nettype none

module ddtw_datapath #(
    parameter int SCREEN_COLUMNS = 20,
    parameter int SCREEN_ROWS    = 18,
    parameter int MAX_DIGITS     = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               write_enable,
    input  wire logic [ddtw_pkg::CFG_INDEX_W-1:0]   write_index,
    input  wire logic [ddtw_pkg::CFG_DATA_W-1:0]    write_data,
    input  wire ddtw_pkg::uword_t                   ctrl,
    output ddtw_pkg::dp_status_t                    status,
    ddtw_in_if.sink                                 digits_in,
    ddtw_out_if.source                              tiles_out
);

    localparam int COL_W = $clog2(MAX_DIGITS + 1);

    logic [7:0]       base_reg;
    logic [7:0]       left_reg;
    logic [7:0]       top_row_reg;
    logic [15:0]      num_reg;
    logic [3:0]       digit_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] count_sat;

    logic             out_valid_reg;
    logic [7:0]       out_column_reg;
    logic [7:0]       out_row_reg;
    logic [7:0]       out_tile_reg;
    logic             out_on_reg;
    logic             out_last_reg;

    logic [32:0]      prod;
    logic [15:0]      quot;
    logic [15:0]      quot_x10;
    logic [3:0]       digit_next;
    logic             out_free;
    logic             in_fire;
    logic             emit_fire;
    logic [7:0]       col_x;
    logic [7:0]       row_y;
    logic [7:0]       tile_n;
    logic             on_scr;
    logic             last_w;

    // configuration writes; the palette has no effect on the tile writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 8'd0;
        end
        else if (write_enable)
        begin
            case (write_index)
                ddtw_pkg::REG_GLYPH_BASE:    base_reg <= write_data;
                ddtw_pkg::REG_DIGIT_PALETTE: base_reg <= base_reg;
                default:                     base_reg <= base_reg;
            endcase
        end
    end

    // handshakes
    assign out_free        = !out_valid_reg || tiles_out.ready;
    assign digits_in.ready = (ctrl.op == ddtw_pkg::OP_LOAD);
    assign in_fire         = digits_in.ready && digits_in.valid;
    assign emit_fire       = (ctrl.op == ddtw_pkg::OP_EMIT) && out_free;

    // clamp the column count
    always_comb
    begin
        if (32'(digits_in.digit_count) > MAX_DIGITS)
        begin
            count_sat = COL_W'(MAX_DIGITS);
        end
        else
        begin
            count_sat = COL_W'(digits_in.digit_count);
        end
    end

    // status to the sequencer
    always_comb
    begin
        case (ctrl.op)
            ddtw_pkg::OP_LOAD: status.go = digits_in.valid;
            ddtw_pkg::OP_EMIT: status.go = out_free;
            default:           status.go = 1'b0;
        endcase
        status.count_zero = (digits_in.digit_count == 4'd0);
        status.col_nz     = (col_reg != '0);
    end

    // divide by ten: quotient by reciprocal, remainder by shift-add
    assign prod       = num_reg * ddtw_pkg::DIV10_MUL;
    assign quot       = 16'(prod >> ddtw_pkg::DIV10_SHIFT);
    assign quot_x10   = (quot << 3) + (quot << 1);
    assign digit_next = 4'(num_reg - quot_x10);

    // conversion registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= count_sat;
        end
        else if (ctrl.op == ddtw_pkg::OP_DIVIDE)
        begin
            col_reg <= col_reg - COL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            left_reg    <= digits_in.left_column;
            top_row_reg <= digits_in.top_row;
            num_reg     <= digits_in.number;
        end
        else if (ctrl.op == ddtw_pkg::OP_DIVIDE)
        begin
            num_reg   <= quot;
            digit_reg <= digit_next;
        end
    end

    // tile write fields
    always_comb
    begin
        col_x  = left_reg + 8'(col_reg);
        row_y  = top_row_reg + {7'd0, ctrl.half};
        tile_n = base_reg + {3'd0, digit_reg, 1'b0} + {7'd0, ctrl.half};
        on_scr = (32'(col_x) < SCREEN_COLUMNS) && (32'(row_y) < SCREEN_ROWS);
        last_w = ctrl.half && (col_reg == '0);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tiles_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_column_reg <= col_x;
            out_row_reg    <= row_y;
            out_tile_reg   <= tile_n;
            out_on_reg     <= on_scr;
            out_last_reg   <= last_w;
        end
    end

    assign tiles_out.valid       = out_valid_reg;
    assign tiles_out.tile_column = out_column_reg;
    assign tiles_out.tile_row    = out_row_reg;
    assign tiles_out.tile_number = out_tile_reg;
    assign tiles_out.on_screen   = out_on_reg;
    assign tiles_out.last        = out_last_reg;

    // the final write of a transaction has no columns left
    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && last_w) |-> (col_reg == '0))
        else $error("last flag with columns remaining");

    // never divide with no column left
    a_divide_col: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == ddtw_pkg::OP_DIVIDE) |-> (col_reg != '0))
        else $error("column counter underflow");

    // an upper half is always followed by a lower half of the same column
    a_pair_column: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !ctrl.half) |=> (ctrl.op == ddtw_pkg::OP_EMIT && ctrl.half
                                       && col_x == $past(col_x)))
        else $error("glyph halves split across columns");

endmodule

`default_nettype wire

@@ hw/rtl/decimal_digit_tile_writer_unit.sv @@
`default_nettype none

// Decimal digit tile writer. Each transaction on digits_in gives a 16-bit
// number, a column count and a tile position; the unit produces two tile
// writes per column on tiles_out (upper glyph half at top_row, lower half at
// top_row+1), rightmost column first, with last set on the final write. A
// count above MAX_DIGITS is clamped, a count of zero produces no writes.
// Control is a five-step microprogram: a load step takes the transaction, then
// each column runs one divide-by-ten step and two tile writes, and a return
// step goes back to load; a write waits while tiles_out stalls, and a count
// of zero stays in the load step. The single output register lets the next
// transaction be taken while the final write still waits. glyph_base_tile
// (index 0) and digit_palette (index 1) are written through write_enable/
// write_index/write_data while the unit is idle; the palette does not appear
// in the tile writes.
module decimal_digit_tile_writer_unit #(
    parameter int SCREEN_COLUMNS = 20,
    parameter int SCREEN_ROWS    = 18,
    parameter int MAX_DIGITS     = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             write_enable,
    input  wire logic [ddtw_pkg::CFG_INDEX_W-1:0] write_index,
    input  wire logic [ddtw_pkg::CFG_DATA_W-1:0]  write_data,
    ddtw_in_if.sink                               digits_in,
    ddtw_out_if.source                            tiles_out
);

    ddtw_pkg::uword_t     ctrl;
    ddtw_pkg::dp_status_t status;

    // microprogram sequencer
    ddtw_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // conversion and tile write datapath
    ddtw_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .MAX_DIGITS     (MAX_DIGITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .ctrl         (ctrl),
        .status       (status),
        .digits_in    (digits_in),
        .tiles_out    (tiles_out)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;

    localparam int SCREEN_COLUMNS = 20;
    localparam int SCREEN_ROWS    = 18;
    localparam int MAX_DIGITS     = 8;

    // settle time after the last write, enough to cover any tail of a transaction
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int MAX_PRINTS     = 50;

    // one tile write as seen on tiles_out
    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] tile;
        logic       on_screen;
        logic       last;
    } tile_write_t;

    // expected tile writes and copies of the configuration registers
    class tile_scoreboard;
        tile_write_t pending_writes[$];
        logic [7:0]  glyph_base;
        logic [2:0]  palette;
        int          errors;
        int          numbers_seen;
        int          writes_checked;

        function new();
            glyph_base     = 8'd0;
            palette        = 3'd0;
            errors         = 0;
            numbers_seen   = 0;
            writes_checked = 0;
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTS)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        function int pending();
            return pending_writes.size();
        endfunction

        // split the number into digits, rightmost column first, two halves each
        function void note_number(input logic [7:0] left, input logic [7:0] top,
                                  input logic [15:0] num, input logic [3:0] cnt);
            tile_write_t w;
            int          cols;
            logic [15:0] rest;
            logic [3:0]  digit;
            cols = (int'(cnt) > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
            rest = num;
            numbers_seen++;
            for (int c = cols - 1; c >= 0; c--)
            begin
                digit = 4'(rest % 16'd10);
                rest  = rest / 16'd10;
                for (int h = 0; h < 2; h++)
                begin
                    w.column    = left + 8'(c);
                    w.row       = top + 8'(h);
                    w.tile      = glyph_base + {3'b000, digit, 1'b0} + 8'(h);
                    w.on_screen = (int'(w.column) < SCREEN_COLUMNS) &&
                                  (int'(w.row) < SCREEN_ROWS);
                    w.last      = (c == 0) && (h == 1);
                    pending_writes.push_back(w);
                end
            end
        endfunction

        // compare one accepted write with the oldest expectation
        task check_write(input tile_write_t got);
            tile_write_t want;
            if (pending_writes.size() == 0)
            begin
                report($sformatf("unexpected write col %0d row %0d tile %0d",
                                 got.column, got.row, got.tile));
            end
            else
            begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (got.column !== want.column)
                    report($sformatf("tile_column %0d, want %0d", got.column, want.column));
                if (got.row !== want.row)
                    report($sformatf("tile_row %0d, want %0d", got.row, want.row));
                if (got.tile !== want.tile)
                    report($sformatf("tile_number %0d, want %0d", got.tile, want.tile));
                if (got.on_screen !== want.on_screen)
                    report($sformatf("on_screen %b, want %b", got.on_screen, want.on_screen));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                             write_enable;
    logic [ddtw_pkg::CFG_INDEX_W-1:0] write_index;
    logic [ddtw_pkg::CFG_DATA_W-1:0]  write_data;

    ddtw_in_if  digits_if ();
    ddtw_out_if tiles_if ();

    tile_scoreboard sb = new();

    int send_idle_pct;
    int stall_pct;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    decimal_digit_tile_writer_unit #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .MAX_DIGITS     (MAX_DIGITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .digits_in    (digits_if.sink),
        .tiles_out    (tiles_if.source)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // register write, only issued while the unit is idle
    task automatic write_reg(input logic [ddtw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] data);
        @(negedge clk);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(negedge clk);
        write_enable <= 1'b0;
        if (idx == ddtw_pkg::REG_GLYPH_BASE)
            sb.glyph_base = data;
        else
            sb.palette = data[2:0];
    endtask

    task automatic set_registers(input logic [7:0] base, input logic [2:0] pal);
        write_reg(ddtw_pkg::REG_GLYPH_BASE, base);
        write_reg(ddtw_pkg::REG_DIGIT_PALETTE, {5'b00000, pal});
    endtask

    // offer one number, with random idle cycles ahead of it
    task automatic send_number(input logic [7:0] left, input logic [7:0] top,
                               input logic [15:0] num, input logic [3:0] cnt);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            digits_if.valid <= 1'b0;
            @(negedge clk);
        end
        digits_if.valid       <= 1'b1;
        digits_if.left_column <= left;
        digits_if.top_row     <= top;
        digits_if.number      <= num;
        digits_if.digit_count <= cnt;
        @(posedge clk);
        while (!digits_if.ready)
            @(posedge clk);
        sb.note_number(left, top, num, cnt);
    endtask

    // mostly on-screen positions and legal counts, now and then anything
    task automatic send_random_number();
        logic [7:0]  left;
        logic [7:0]  top;
        logic [15:0] num;
        logic [3:0]  cnt;
        int          pick;
        pick = $urandom_range(9);
        left = (pick < 7) ? 8'($urandom_range(24)) : 8'($urandom);
        pick = $urandom_range(9);
        top  = (pick < 7) ? 8'($urandom_range(20)) : 8'($urandom);
        pick = $urandom_range(9);
        if (pick < 8)
            cnt = 4'($urandom_range(8, 1));
        else if (pick == 8)
            cnt = 4'd0;
        else
            cnt = 4'($urandom_range(15, 9));
        pick = $urandom_range(9);
        if (pick < 6)
            num = 16'($urandom);
        else if (pick < 8)
            num = 16'($urandom_range(999));
        else if (pick == 8)
            num = 16'hffff;
        else
            num = 16'd0;
        send_number(left, top, num, cnt);
    endtask

    // stop offering and wait until every tile write has come out
    task automatic drain_writes();
        @(negedge clk);
        digits_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        tiles_if.ready = 1'b0;
        hold_left      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tiles_if.ready <= 1'b0;
            end
            else
            begin
                tiles_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // check every accepted tile write
    always @(posedge clk)
    begin
        if (rst_n && tiles_if.valid && tiles_if.ready)
            sb.check_write('{column: tiles_if.tile_column, row: tiles_if.tile_row,
                             tile: tiles_if.tile_number, on_screen: tiles_if.on_screen,
                             last: tiles_if.last});
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((digits_if.valid && digits_if.ready) || (tiles_if.valid && tiles_if.ready) ||
            write_enable || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d writes outstanding", sb.pending());
            $display("tb: errors");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n                 = 1'b0;
        write_enable          = 1'b0;
        write_index           = '0;
        write_data            = '0;
        digits_if.valid       = 1'b0;
        digits_if.left_column = 8'd0;
        digits_if.top_row     = 8'd0;
        digits_if.number      = 16'd0;
        digits_if.digit_count = 4'd0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        hold_request          = 1'b0;
        quiet_cycles          = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero count, clamped count, wraps, screen edges
        set_registers(8'd0, 3'd0);
        send_number(8'd0,   8'd0,   16'd0,     4'd1);
        send_number(8'd0,   8'd0,   16'd65535, 4'd5);
        send_number(8'd2,   8'd3,   16'd12345, 4'd8);
        send_number(8'd5,   8'd5,   16'd9,     4'd0);
        send_number(8'd1,   8'd1,   16'd65535, 4'd2);
        send_number(8'd4,   8'd2,   16'd40321, 4'd9);
        send_number(8'd4,   8'd2,   16'd40321, 4'd15);
        send_number(8'd3,   8'd255, 16'd77,    4'd2);
        send_number(8'd254, 8'd6,   16'd5678,  4'd4);
        send_number(8'd255, 8'd255, 16'd65535, 4'd8);
        send_number(8'd12,  8'd16,  16'd24680, 4'd8);
        send_number(8'd16,  8'd17,  16'd1357,  4'd4);
        send_number(8'd19,  8'd0,   16'd7,     4'd1);
        send_number(8'd20,  8'd0,   16'd8,     4'd1);
        send_number(8'd0,   8'd18,  16'd3,     4'd3);
        send_number(8'd10,  8'd10,  16'd59999, 4'd6);
        send_number(8'd0,   8'd0,   16'd1000,  4'd3);
        send_number(8'd170, 8'd85,  16'hAAAA,  4'd7);
        send_number(8'd85,  8'd170, 16'h5555,  4'd8);
        drain_writes();
        set_registers(8'd255, 3'd7);
        send_number(8'd0,   8'd0,   16'd58765, 4'd5);
        send_number(8'd8,   8'd8,   16'd42,    4'd0);
        drain_writes();

        // random phases under varied idling and register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            case (phase)
                0:       set_registers(8'd255, 3'd7);
                1:       set_registers(8'd0, 3'd0);
                4:       set_registers(8'd236, 3'd5);
                default: set_registers(8'($urandom), 3'($urandom));
            endcase
            // let the output back up into the input while numbers keep coming
            if (phase == 2)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_number();
            drain_writes();
        end

        $display("summary: %0d numbers sent, %0d tile writes checked", sb.numbers_seen,
                 sb.writes_checked);
        $display("summary: %0d phases of mixed idling, glyph base and palette at extremes",
                 PHASES);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/ddtw_pkg.sv
hw/rtl/ddtw_if.sv
hw/rtl/ddtw_useq.sv
hw/rtl/ddtw_datapath.sv
hw/rtl/decimal_digit_tile_writer_unit.sv
verif/tb.sv
